>>> rtl/cor_pkg.sv
// shared widths and sideband types for the circle overlap resolver
package cor_pkg;

    localparam int POS_W   = 32;               // q16.16 positions
    localparam int RAD_W   = 24;               // q8.16 radii
    localparam int MD_W    = RAD_W + 1;        // summed radii
    localparam int SQ_W    = 2 * MD_W;         // one squared component
    localparam int DSQ_W   = SQ_W + 2;         // radicand, even width
    localparam int ROOT_W  = DSQ_W / 2;        // integer square root
    localparam int SREM_W  = ROOT_W + 3;       // square root partial remainder
    localparam int NUM_W   = DSQ_W;            // rounded dividend
    localparam int DEN_W   = ROOT_W + 1;       // twice the distance
    localparam int QUO_W   = ROOT_W;           // push magnitude

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        pos_t            ax;
        pos_t            ay;
        pos_t            bx;
        pos_t            by;
        logic [MD_W-1:0] md;
        logic [MD_W-1:0] adx;
        logic [MD_W-1:0] ady;
        logic            sx;
        logic            sy;
        logic            hit;
    } sqrt_side_t;

    typedef struct packed {
        pos_t ax;
        pos_t ay;
        pos_t bx;
        pos_t by;
        logic sx;
        logic sy;
        logic hit;
    } div_side_t;

endpackage

>>> rtl/cor_isqrt.sv
// pipelined integer square root, one root bit per stage
module cor_isqrt
    import cor_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DSQ_W-1:0]  in_rad,
    input  sqrt_side_t        in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output sqrt_side_t        out_side
);

    localparam int N = ROOT_W;

    logic              vld_reg  [N];
    logic [DSQ_W-1:0]  rad_reg  [N];
    logic [SREM_W-1:0] rem_reg  [N];
    logic [ROOT_W-1:0] root_reg [N];
    sqrt_side_t        side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic              pv;
            logic [DSQ_W-1:0]  prad;
            logic [SREM_W-1:0] prem;
            logic [ROOT_W-1:0] proot;
            sqrt_side_t        pside;
            logic [SREM_W-1:0] r_in;
            logic [SREM_W-1:0] trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign pv    = in_valid;
                assign prad  = in_rad;
                assign prem  = '0;
                assign proot = '0;
                assign pside = in_side;
            end else begin : g_next
                assign pv    = vld_reg[k-1];
                assign prad  = rad_reg[k-1];
                assign prem  = rem_reg[k-1];
                assign proot = root_reg[k-1];
                assign pside = side_reg[k-1];
            end

            // bring down two radicand bits, try root*4+1
            always_comb begin
                r_in  = {prem[SREM_W-3:0], prad[DSQ_W-1 -: 2]};
                trial = SREM_W'({proot, 2'b01});
                ge    = (r_in >= trial);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= pv;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= {prad[DSQ_W-3:0], 2'b00};
                    rem_reg[k]  <= ge ? (r_in - trial) : r_in;
                    root_reg[k] <= {proot[ROOT_W-2:0], ge};
                    side_reg[k] <= pside;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

>>> rtl/cor_div.sv
// pipelined restoring divider, two dividends over one divisor, one quotient bit per stage
module cor_div
    import cor_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num_x,
    input  logic [NUM_W-1:0] in_num_y,
    input  logic [DEN_W-1:0] in_den,
    input  div_side_t        in_side,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_q_x,
    output logic [QUO_W-1:0] out_q_y,
    output div_side_t        out_side
);

    localparam int N  = QUO_W;
    localparam int TW = NUM_W;

    logic             vld_reg  [N];
    logic [NUM_W-1:0] remx_reg [N];
    logic [NUM_W-1:0] remy_reg [N];
    logic [QUO_W-1:0] qx_reg   [N];
    logic [QUO_W-1:0] qy_reg   [N];
    logic [DEN_W-1:0] den_reg  [N];
    div_side_t        side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            localparam int SH = N - 1 - k;
            logic             pv;
            logic [NUM_W-1:0] premx;
            logic [NUM_W-1:0] premy;
            logic [QUO_W-1:0] pqx;
            logic [QUO_W-1:0] pqy;
            logic [DEN_W-1:0] pden;
            div_side_t        pside;
            logic [TW-1:0]    trial;
            logic             gex;
            logic             gey;

            if (k == 0) begin : g_first
                assign pv    = in_valid;
                assign premx = in_num_x;
                assign premy = in_num_y;
                assign pqx   = '0;
                assign pqy   = '0;
                assign pden  = in_den;
                assign pside = in_side;
            end else begin : g_next
                assign pv    = vld_reg[k-1];
                assign premx = remx_reg[k-1];
                assign premy = remy_reg[k-1];
                assign pqx   = qx_reg[k-1];
                assign pqy   = qy_reg[k-1];
                assign pden  = den_reg[k-1];
                assign pside = side_reg[k-1];
            end

            always_comb begin
                trial = TW'(pden) << SH;
                gex   = (premx >= trial);
                gey   = (premy >= trial);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= pv;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    remx_reg[k] <= gex ? (premx - trial) : premx;
                    remy_reg[k] <= gey ? (premy - trial) : premy;
                    qx_reg[k]   <= {pqx[QUO_W-2:0], gex};
                    qy_reg[k]   <= {pqy[QUO_W-2:0], gey};
                    den_reg[k]  <= pden;
                    side_reg[k] <= pside;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_q_x   = qx_reg[N-1];
    assign out_q_y   = qy_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

>>> rtl/circle_overlap_resolver_core.sv
// top level of the circle overlap resolver pipeline
// Resolves the overlap of two circles given as q16.16 centres and q8.16 radii.
// One request enters per clock while the pipeline advances, one result leaves
// per request, in order, through four front stages, 26 square root stages,
// two rounded-dividend stages, 26 divider stages and one output stage. The
// whole pipeline advances together whenever the output register is empty or
// being taken, so s_ready follows m_ready combinationally; bubbles in the
// stream are carried along as cleared valid bits. The distance is the floor
// square root of the squared centre distance, the push is half the overlap
// along the normal rounded to nearest with ties away from zero, and outputs
// saturate to the signed 32-bit range. m_touched flags overlapping requests.
module circle_overlap_resolver_core
    import cor_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [POS_W-1:0] s_a_x,
    input  logic [POS_W-1:0] s_a_y,
    input  logic [POS_W-1:0] s_b_x,
    input  logic [POS_W-1:0] s_b_y,
    input  logic [RAD_W-1:0] s_a_radius,
    input  logic [RAD_W-1:0] s_b_radius,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_new_a_x,
    output logic [POS_W-1:0] m_new_a_y,
    output logic [POS_W-1:0] m_new_b_x,
    output logic [POS_W-1:0] m_new_b_y,
    output logic             m_touched
);

    // clamp a 33-bit sum to the 32-bit signed range
    function automatic logic [POS_W-1:0] sat33(input logic [POS_W:0] v);
        logic [POS_W-1:0] r;
        begin
            if (v[POS_W] != v[POS_W-1]) begin
                r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                r = v[POS_W-1:0];
            end
            return r;
        end
    endfunction

    // global advance: the pipeline moves whenever the output slot frees up
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 0: capture request, sum the radii
    logic            s0_vld_reg;
    pos_t            s0_ax_reg, s0_ay_reg, s0_bx_reg, s0_by_reg;
    logic [MD_W-1:0] s0_md_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_ax_reg <= s_a_x;
            s0_ay_reg <= s_a_y;
            s0_bx_reg <= s_b_x;
            s0_by_reg <= s_b_y;
            s0_md_reg <= MD_W'(s_a_radius) + MD_W'(s_b_radius);
        end
    end

    // stage 1: centre difference, magnitudes and the far-apart test
    logic [POS_W:0] dx_next, dy_next, adx_next, ady_next;
    logic           near_next;

    always_comb begin
        dx_next   = {s0_bx_reg[POS_W-1], s0_bx_reg} - {s0_ax_reg[POS_W-1], s0_ax_reg};
        dy_next   = {s0_by_reg[POS_W-1], s0_by_reg} - {s0_ay_reg[POS_W-1], s0_ay_reg};
        adx_next  = dx_next[POS_W] ? (~dx_next + 1'b1) : dx_next;
        ady_next  = dy_next[POS_W] ? (~dy_next + 1'b1) : dy_next;
        // far apart on either axis means no overlap, and keeps squares in range
        near_next = (adx_next < (POS_W+1)'(s0_md_reg)) && (ady_next < (POS_W+1)'(s0_md_reg));
    end

    logic            s1_vld_reg;
    pos_t            s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic [MD_W-1:0] s1_md_reg, s1_adx_reg, s1_ady_reg;
    logic            s1_sx_reg, s1_sy_reg, s1_near_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ax_reg   <= s0_ax_reg;
            s1_ay_reg   <= s0_ay_reg;
            s1_bx_reg   <= s0_bx_reg;
            s1_by_reg   <= s0_by_reg;
            s1_md_reg   <= s0_md_reg;
            s1_adx_reg  <= adx_next[MD_W-1:0];
            s1_ady_reg  <= ady_next[MD_W-1:0];
            s1_sx_reg   <= dx_next[POS_W];
            s1_sy_reg   <= dy_next[POS_W];
            s1_near_reg <= near_next;
        end
    end

    // stage 2: the three squares
    logic            s2_vld_reg;
    sqrt_side_t      s2_side_reg;
    logic            s2_near_reg;
    logic [SQ_W-1:0] s2_dxsq_reg, s2_dysq_reg, s2_mdsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_dxsq_reg      <= SQ_W'(s1_adx_reg) * SQ_W'(s1_adx_reg);
            s2_dysq_reg      <= SQ_W'(s1_ady_reg) * SQ_W'(s1_ady_reg);
            s2_mdsq_reg      <= SQ_W'(s1_md_reg) * SQ_W'(s1_md_reg);
            s2_near_reg      <= s1_near_reg;
            s2_side_reg.ax   <= s1_ax_reg;
            s2_side_reg.ay   <= s1_ay_reg;
            s2_side_reg.bx   <= s1_bx_reg;
            s2_side_reg.by   <= s1_by_reg;
            s2_side_reg.md   <= s1_md_reg;
            s2_side_reg.adx  <= s1_adx_reg;
            s2_side_reg.ady  <= s1_ady_reg;
            s2_side_reg.sx   <= s1_sx_reg;
            s2_side_reg.sy   <= s1_sy_reg;
            s2_side_reg.hit  <= 1'b0;
        end
    end

    // stage 3: squared distance and the overlap decision
    logic [DSQ_W-1:0] dsq_next;
    sqrt_side_t       s3_side_next;
    assign dsq_next = DSQ_W'(s2_dxsq_reg) + DSQ_W'(s2_dysq_reg);

    always_comb begin
        s3_side_next     = s2_side_reg;
        // coincident centres have no normal, exact touch is no overlap
        s3_side_next.hit = s2_near_reg && (dsq_next != '0)
                           && (dsq_next < DSQ_W'(s2_mdsq_reg));
    end

    logic             s3_vld_reg;
    logic [DSQ_W-1:0] s3_dsq_reg;
    sqrt_side_t       s3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_dsq_reg  <= dsq_next;
            s3_side_reg <= s3_side_next;
        end
    end

    // square root unit
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    sqrt_side_t        sq_side;

    cor_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .in_rad    (s3_dsq_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage 4: overlap and the two products; dist < md whenever hit
    logic [MD_W-1:0] ov_next;
    assign ov_next = sq_side.md - sq_root[MD_W-1:0];

    logic              s4_vld_reg;
    logic [SQ_W-1:0]   s4_numx_reg, s4_numy_reg;
    logic [ROOT_W-1:0] s4_dist_reg;
    div_side_t         s4_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_numx_reg     <= SQ_W'(ov_next) * SQ_W'(sq_side.adx);
            s4_numy_reg     <= SQ_W'(ov_next) * SQ_W'(sq_side.ady);
            s4_dist_reg     <= sq_root;
            s4_side_reg.ax  <= sq_side.ax;
            s4_side_reg.ay  <= sq_side.ay;
            s4_side_reg.bx  <= sq_side.bx;
            s4_side_reg.by  <= sq_side.by;
            s4_side_reg.sx  <= sq_side.sx;
            s4_side_reg.sy  <= sq_side.sy;
            s4_side_reg.hit <= sq_side.hit;
        end
    end

    // stage 5: add half the divisor for round-to-nearest, double the distance
    logic             s5_vld_reg;
    logic [NUM_W-1:0] s5_numx_reg, s5_numy_reg;
    logic [DEN_W-1:0] s5_den_reg;
    div_side_t        s5_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (en) begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_numx_reg <= NUM_W'(s4_numx_reg) + NUM_W'(s4_dist_reg);
            s5_numy_reg <= NUM_W'(s4_numy_reg) + NUM_W'(s4_dist_reg);
            s5_den_reg  <= {s4_dist_reg, 1'b0};
            s5_side_reg <= s4_side_reg;
        end
    end

    // divider unit, shared divisor for both axes
    logic             dv_vld;
    logic [QUO_W-1:0] dv_qx, dv_qy;
    div_side_t        dv_side;

    cor_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s5_vld_reg),
        .in_num_x  (s5_numx_reg),
        .in_num_y  (s5_numy_reg),
        .in_den    (s5_den_reg),
        .in_side   (s5_side_reg),
        .out_valid (dv_vld),
        .out_q_x   (dv_qx),
        .out_q_y   (dv_qy),
        .out_side  (dv_side)
    );

    // output stage: apply the signed push and saturate
    logic [POS_W:0] px_next, py_next, pxn_next, pyn_next;
    logic [POS_W:0] ax_ext, ay_ext, bx_ext, by_ext;

    always_comb begin
        px_next  = dv_side.hit ? (POS_W+1)'(dv_qx) : '0;
        py_next  = dv_side.hit ? (POS_W+1)'(dv_qy) : '0;
        // push carries the sign of the centre difference
        if (dv_side.sx) begin
            px_next = ~px_next + 1'b1;
        end
        if (dv_side.sy) begin
            py_next = ~py_next + 1'b1;
        end
        pxn_next = ~px_next + 1'b1;
        pyn_next = ~py_next + 1'b1;
        ax_ext   = {dv_side.ax[POS_W-1], dv_side.ax};
        ay_ext   = {dv_side.ay[POS_W-1], dv_side.ay};
        bx_ext   = {dv_side.bx[POS_W-1], dv_side.bx};
        by_ext   = {dv_side.by[POS_W-1], dv_side.by};
    end

    logic [POS_W-1:0] new_ax_reg, new_ay_reg, new_bx_reg, new_by_reg;
    logic             touched_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            new_ax_reg  <= sat33(ax_ext + pxn_next);
            new_ay_reg  <= sat33(ay_ext + pyn_next);
            new_bx_reg  <= sat33(bx_ext + px_next);
            new_by_reg  <= sat33(by_ext + py_next);
            touched_reg <= dv_side.hit;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_new_a_x = new_ax_reg;
    assign m_new_a_y = new_ay_reg;
    assign m_new_b_x = new_bx_reg;
    assign m_new_b_y = new_by_reg;
    assign m_touched = touched_reg;

endmodule

>>> rtl/cor_checker.sv
// port-level checks for the circle overlap resolver, bound to the top level
module cor_checker
    import cor_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [POS_W-1:0] s_a_x,
    input logic [POS_W-1:0] s_a_y,
    input logic [POS_W-1:0] s_b_x,
    input logic [POS_W-1:0] s_b_y,
    input logic [RAD_W-1:0] s_a_radius,
    input logic [RAD_W-1:0] s_b_radius,
    input logic             m_valid,
    input logic             m_ready,
    input logic [POS_W-1:0] m_new_a_x,
    input logic [POS_W-1:0] m_new_a_y,
    input logic [POS_W-1:0] m_new_b_x,
    input logic [POS_W-1:0] m_new_b_y,
    input logic             m_touched
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // the pipeline takes a request whenever the output slot frees up
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output slot");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_a_x) && $stable(m_new_a_y)
            && $stable(m_new_b_x) && $stable(m_new_b_y) && $stable(m_touched))
        else $error("stalled result changed");

    // while stalled nothing is taken at the input
    a_no_take_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while output stalled");

endmodule

bind circle_overlap_resolver_core cor_checker u_cor_checker (.*);
